FILE: hw/rtl/evg_pkg.sv
// ----------------------------------------------------------------------------
// evg_pkg
// Shared types, constants and helpers for the ellipse vertex generator.
// ----------------------------------------------------------------------------
package evg_pkg;

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned RAD_W   = 16;
  localparam int unsigned COORD_W = 17;
  localparam int unsigned CW      = 34;   // CORDIC x, y, z width (signed Q30)
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned PROD_W  = 49;   // |v| (33 bits) times radius

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [CW-1:0] GAIN_Q30  = 34'd652032874;
  localparam logic [19:0] COORD_MAX   = 20'd65535;

  // configuration register indexes
  localparam logic [1:0] REG_X_RADIUS = 2'd0;
  localparam logic [1:0] REG_Y_RADIUS = 2'd1;
  localparam logic [1:0] REG_POINTS   = 2'd2;

  typedef struct packed {
    logic valid;
    logic err;
    logic last;
  } meta_t;

  typedef struct packed {
    logic [CNT_W-1:0]   rem;
    logic [PHASE_W-1:0] quo;
  } div_t;

  // four restoring division steps, bits entered MSB first
  function automatic div_t div_step4(div_t d, logic [3:0] bits, logic [CNT_W-1:0] cnt);
    div_t           r;
    logic [CNT_W:0] t;
    r = d;
    for (int k = 3; k >= 0; k--) begin
      t = {r.rem, bits[k]};
      if (t >= {1'b0, cnt}) begin
        r.rem = CNT_W'(t - {1'b0, cnt});
        r.quo = {r.quo[PHASE_W-2:0], 1'b1};
      end else begin
        r.rem = t[CNT_W-1:0];
        r.quo = {r.quo[PHASE_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // atan(2^-i) in Q30 radians, truncated
  function automatic logic [CW-1:0] atan_q30(int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd843314856;
      1:  a = 32'd497837829;
      2:  a = 32'd263043836;
      3:  a = 32'd133525158;
      4:  a = 32'd67021686;
      5:  a = 32'd33543515;
      6:  a = 32'd16775850;
      7:  a = 32'd8388437;
      8:  a = 32'd4194282;
      9:  a = 32'd2097149;
      10: a = 32'd1048575;
      11: a = 32'd524287;
      12: a = 32'd262143;
      13: a = 32'd131071;
      14: a = 32'd65535;
      15: a = 32'd32767;
      16: a = 32'd16383;
      17: a = 32'd8191;
      18: a = 32'd4095;
      19: a = 32'd2047;
      20: a = 32'd1023;
      21: a = 32'd511;
      22: a = 32'd255;
      23: a = 32'd127;
      default: a = 32'd0;
    endcase
    return {2'b00, a};
  endfunction

endpackage

FILE: hw/rtl/ellipse_vertex_generator_top.sv
// ----------------------------------------------------------------------------
// ellipse_vertex_generator_top
// Point on an ellipse per vertex index, CORDIC sine/cosine, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per vertex index (tdata[11:0] = point_index).
//   out_* : one word per vertex: tdata holds x_coord and y_coord (signed
//           Q17.0), tlast marks the last index of the run, tuser flags an
//           index at or beyond the point count (coordinates then zero).
//   cfg_* : register writes (0 x_radius, 1 y_radius, 2 points_in_use),
//           always ready; write only while no word is in flight.
// The stages are, in order: an input register, eight radix-16 phase divider
// stages, two stages of angle scaling, one stage per CORDIC iteration
// (CORDIC_STAGES, 18 by default), a radius multiply stage and an output
// register.
// Throughput is one word per cycle. Every stage advances together; when the
// receiver stalls with a word waiting at the output, the whole pipeline
// holds and in_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads x_radius = y_radius = 0 and
// points_in_use = 8.
// ----------------------------------------------------------------------------
module ellipse_vertex_generator_top #(
  parameter int MAX_POINTS    = 4096,
  parameter int CORDIC_STAGES = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [11:0] point_index, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // [16:0] x_coord, [33:17] y_coord, rest zero
  output logic        out_tlast,    // last_point
  output logic        out_tuser,    // [0] index_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW     = evg_pkg::CW;
  localparam int CNT_W  = evg_pkg::CNT_W;
  localparam int DIV_ST = 8;
  localparam int P_DIV  = 1;
  localparam int P_MUL  = P_DIV + DIV_ST;
  localparam int P_Z    = P_MUL + 1;
  localparam int P_COR  = P_Z + 1;
  localparam int P_PRD  = P_COR + CORDIC_STAGES;
  localparam int DEPTH  = P_PRD + 2;
  localparam logic [16:0] MAXP = 17'(MAX_POINTS);

  // configuration
  logic [evg_pkg::RAD_W-1:0] xrad_r, yrad_r;
  logic [CNT_W-1:0]          pts_r, cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xrad_r <= '0;
      yrad_r <= '0;
      pts_r  <= CNT_W'(8);
    end else if (cfg_valid) begin
      case (cfg_index)
        evg_pkg::REG_X_RADIUS: xrad_r <= cfg_data;
        evg_pkg::REG_Y_RADIUS: yrad_r <= cfg_data;
        evg_pkg::REG_POINTS:   pts_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cnt = ({4'b0, pts_r} > MAXP) ? MAXP[CNT_W-1:0] : pts_r;

  // pipeline control
  evg_pkg::meta_t meta_r [DEPTH];
  logic           en;

  assign en        = !meta_r[DEPTH-1].valid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) meta_r[k] <= '0;
    end else if (en) begin
      meta_r[0].valid <= in_tvalid;
      meta_r[0].err   <= {1'b0, in_tdata[11:0]} >= cnt;
      meta_r[0].last  <= {1'b0, in_tdata[11:0]} == CNT_W'(cnt - 1'b1);
      for (int k = 1; k < DEPTH; k++) meta_r[k] <= meta_r[k-1];
    end
  end

  // phase = round(idx * 2^32 / cnt), radix-16 restoring divider
  logic [evg_pkg::IDX_W-1:0] idx_r;
  evg_pkg::div_t             div_in;
  evg_pkg::div_t             div_r [1:DIV_ST];
  logic [31:0]               low_word;

  assign low_word = {20'b0, cnt[CNT_W-1:1]};

  always_ff @(posedge clk) begin
    if (en) idx_r <= in_tdata[11:0];
  end

  // remainder starts at idx, quotient at zero
  assign div_in = {1'b0, idx_r, 32'b0};

  always_ff @(posedge clk) begin
    if (en) div_r[1] <= evg_pkg::div_step4(div_in, low_word[31:28], cnt);
  end

  for (genvar d = 1; d < DIV_ST; d++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) div_r[d+1] <= evg_pkg::div_step4(div_r[d], low_word[31-4*d -: 4], cnt);
    end
  end

  // angle in quadrant to Q30 radians, split multiply
  logic [45:0] ph_r, pl_r;
  logic [1:0]  qd_r [P_MUL:P_PRD-1];
  logic [61:0] zsum;
  logic [CW-1:0] cx_r [CORDIC_STAGES+1];
  logic [CW-1:0] cy_r [CORDIC_STAGES+1];
  logic [CW-1:0] cz_r [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r       <= 46'(div_r[DIV_ST].quo[29:15] * evg_pkg::HALF_PI_Q30);
      pl_r       <= 46'(div_r[DIV_ST].quo[14:0] * evg_pkg::HALF_PI_Q30);
      qd_r[P_MUL] <= div_r[DIV_ST].quo[31:30];
    end
  end

  assign zsum = {1'b0, ph_r, 15'b0} + {16'b0, pl_r} + 62'(1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]   <= evg_pkg::GAIN_Q30;
      cy_r[0]   <= '0;
      cz_r[0]   <= {2'b00, zsum[61:30]};
      qd_r[P_Z] <= qd_r[P_MUL];
    end
  end

  // one rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
    logic signed [CW-1:0] dx, dy;
    assign dx = $signed(cy_r[i]) >>> i;
    assign dy = $signed(cx_r[i]) >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz_r[i][CW-1]) begin
          cx_r[i+1] <= cx_r[i] - dx;
          cy_r[i+1] <= cy_r[i] + dy;
          cz_r[i+1] <= cz_r[i] - evg_pkg::atan_q30(i);
        end else begin
          cx_r[i+1] <= cx_r[i] + dx;
          cy_r[i+1] <= cy_r[i] - dy;
          cz_r[i+1] <= cz_r[i] + evg_pkg::atan_q30(i);
        end
        qd_r[P_COR+i] <= qd_r[P_COR+i-1];
      end
    end
  end

  // quadrant rotation and radius multiply
  logic [CW-1:0] c_q, s_q, c_f, s_f, mag_x, mag_y;
  logic [evg_pkg::PROD_W-1:0] prod_x_r, prod_y_r;
  logic neg_x_r, neg_y_r;

  assign c_f = cx_r[CORDIC_STAGES];
  assign s_f = cy_r[CORDIC_STAGES];

  always_comb begin
    case (qd_r[P_PRD-1])
      2'd1:    begin c_q = -s_f; s_q = c_f;  end
      2'd2:    begin c_q = -c_f; s_q = -s_f; end
      2'd3:    begin c_q = s_f;  s_q = -c_f; end
      default: begin c_q = c_f;  s_q = s_f;  end
    endcase
    mag_x = c_q[CW-1] ? -c_q : c_q;
    mag_y = s_q[CW-1] ? -s_q : s_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x_r <= evg_pkg::PROD_W'(mag_x[32:0] * xrad_r);
      prod_y_r <= evg_pkg::PROD_W'(mag_y[32:0] * yrad_r);
      neg_x_r  <= c_q[CW-1];
      neg_y_r  <= s_q[CW-1];
    end
  end

  // round half away from zero, saturate, restore sign
  logic [49:0] rnd_x, rnd_y;
  logic [19:0] px, py;
  logic [16:0] ox, oy;
  logic [16:0] x_r, y_r;

  assign rnd_x = {1'b0, prod_x_r} + 50'(1 << 29);
  assign rnd_y = {1'b0, prod_y_r} + 50'(1 << 29);

  always_comb begin
    px = (rnd_x[49:30] > evg_pkg::COORD_MAX) ? evg_pkg::COORD_MAX : rnd_x[49:30];
    py = (rnd_y[49:30] > evg_pkg::COORD_MAX) ? evg_pkg::COORD_MAX : rnd_y[49:30];
    ox = neg_x_r ? -px[16:0] : px[16:0];
    oy = neg_y_r ? -py[16:0] : py[16:0];
    if (meta_r[DEPTH-2].err) begin
      ox = '0;
      oy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= ox;
      y_r <= oy;
    end
  end

  assign out_tvalid = meta_r[DEPTH-1].valid;
  assign out_tdata  = {6'b0, y_r, x_r};
  assign out_tlast  = meta_r[DEPTH-1].last && !meta_r[DEPTH-1].err;
  assign out_tuser  = meta_r[DEPTH-1].err;

endmodule
